// ===== rtl/core/mtgr_pkg.sv =====
// Shared types and constants of the multi-touch gesture recognizer.
package mtgr_pkg;

  typedef enum logic [1:0] {
    OP_DOWN    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_UP      = 2'd2,
    OP_PROCESS = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TAP  = 2'd0,
    KIND_PAN  = 2'd1,
    KIND_LONG = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_BEGAN   = 2'd0,
    PH_CHANGED = 2'd1,
    PH_ENDED   = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_TAP_MAX_SPREAD = 3'd0;
  localparam logic [2:0] REG_PAN_MIN_MOVE   = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS_MIN = 3'd2;
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd3;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd4;

  localparam logic [15:0] TAP_MAX_SPREAD_RST = 16'd75;
  localparam logic [11:0] PAN_MIN_MOVE_RST   = 12'd4;
  localparam logic [15:0] LONG_PRESS_MIN_RST = 16'd500;
  localparam logic [12:0] SCREEN_WIDTH_RST   = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST  = 13'd480;

  localparam logic [11:0] PIX_MAX = 12'hFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] finger_id;
    logic [31:0] event_time;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  gesture_kind;
    logic [1:0]  gesture_phase;
    logic [3:0]  finger_count;
    logic [11:0] centroid_x;
    logic [11:0] centroid_y;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_FIND,
    ST_WRITE,
    ST_START,
    ST_GROW,
    ST_OPEN,
    ST_SPLIT,
    ST_DECIDE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  // What the finish step does with the divider results.
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_HELD_CHG,
    MODE_HELD_END,
    MODE_TAP,
    MODE_MOTION
  } mode_t;

endpackage

// ===== rtl/core/multi_touch_gesture_recognizer.sv =====
// Top level of the multi-touch gesture recognizer: slot table, sequencer and shared units.
//
// Usage: a command is transferred when start is high and busy is low. Finger down,
// move and up commands update a table of FINGER_SLOTS finger slots; a process
// command scans the table and may produce one gesture result. A result is shown on
// result for exactly one cycle with result_valid high; the receiver cannot stall it.
// Configuration registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data; the user must write them only while busy is low (unchecked).
//
// Steps: down, move and up keep busy high while the one multiplier scales x and then
// y, through a slot scan of one slot a cycle and a table write. Process scans the
// table to find the sequence start (and ends there when no slot is used); when the
// start finger is still down it goes straight on, and when it is lifted it widens
// the end time in passes over the table until a pass changes nothing, then scans
// for fingers still down. It then scans to split the sequence, decides, runs D
// divisions (2 for a tap or a held change, 4 for a new motion) of SW quotient bits
// each (SW = 16 at ten slots) and takes a finish step when a result may follow.
// A result appears in the first cycle in which busy is low again. Reset clears the
// slot table, the held gesture and the registers to defaults.
module multi_touch_gesture_recognizer #(
  parameter int FINGER_SLOTS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mtgr_pkg::cmd_t       cmd,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 result_valid,
  output mtgr_pkg::result_t    result
);

  localparam int IW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
  localparam int CW = $clog2(FINGER_SLOTS + 1);
  localparam int SW = 12 + CW;
  localparam int BW = (SW > 1) ? $clog2(SW) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(FINGER_SLOTS - 1);
  localparam logic [BW-1:0] LAST_BIT = BW'(SW - 1);

  // Configuration registers.
  logic [15:0] tap_max_spread;
  logic [11:0] pan_min_move;
  logic [15:0] long_press_min;
  logic [12:0] screen_width;
  logic [12:0] screen_height;

  // Slot table.
  logic                 slot_used       [FINGER_SLOTS];
  logic [31:0]          slot_finger     [FINGER_SLOTS];
  logic [11:0]          slot_start_x    [FINGER_SLOTS];
  logic [11:0]          slot_start_y    [FINGER_SLOTS];
  logic [31:0]          slot_start_time [FINGER_SLOTS];
  logic [11:0]          slot_now_x      [FINGER_SLOTS];
  logic [11:0]          slot_now_y      [FINGER_SLOTS];
  logic [31:0]          slot_now_time   [FINGER_SLOTS];
  mtgr_pkg::phase_t     slot_phase      [FINGER_SLOTS];

  // Held continuous gesture.
  mtgr_pkg::kind_t      held_kind;
  mtgr_pkg::phase_t     held_phase;
  logic [CW-1:0]        held_count;
  logic [11:0]          held_x;
  logic [11:0]          held_y;

  // Sequencer and working registers.
  mtgr_pkg::state_t     state, state_next;
  mtgr_pkg::cmd_t       cmd_r;
  mtgr_pkg::mode_t      mode;
  logic [IW-1:0]        idx;
  logic [11:0]          pix_x, pix_y;
  logic                 have_m, have_f;
  logic [IW-1:0]        m_idx, f_idx;
  logic                 have_start;
  logic [IW-1:0]        start_idx;
  logic [31:0]          t0, t1;
  logic                 grow_changed;
  logic                 seq_open;
  logic [CW-1:0]        na, nl;
  logic [SW-1:0]        sum_ax, sum_ay, sum_bx, sum_by, sum_lx, sum_ly;
  logic [31:0]          smin, smax, emin, emax;
  logic [31:0]          first_st;
  logic [1:0]           div_sel;
  logic [BW-1:0]        div_bit;
  logic [SW-1:0]        dq;
  logic [CW:0]          rem;
  logic [11:0]          cx, cy, bx, by;

  // Shared scaling multiplier: x in state ST_SCALE_X, then y in ST_SCALE_Y.
  logic [15:0] mul_a;
  logic [12:0] mul_b;
  logic [28:0] mul_p;
  logic [11:0] mul_pix;
  assign mul_a   = (state == mtgr_pkg::ST_SCALE_X) ? cmd_r.norm_x : cmd_r.norm_y;
  assign mul_b   = (state == mtgr_pkg::ST_SCALE_X) ? screen_width : screen_height;
  assign mul_p   = 29'(mul_a) * 29'(mul_b);
  assign mul_pix = mul_p[28] ? mtgr_pkg::PIX_MAX : mul_p[27:16];

  // Current scan slot.
  logic             cur_used;
  logic [31:0]      cur_st, cur_nt;
  mtgr_pkg::phase_t cur_ph;
  logic             cur_ended;
  logic             scan_last;
  assign cur_used  = slot_used[idx];
  assign cur_st    = slot_start_time[idx];
  assign cur_nt    = slot_now_time[idx];
  assign cur_ph    = slot_phase[idx];
  assign cur_ended = (cur_ph == mtgr_pkg::PH_ENDED);
  assign scan_last = (idx == LAST_SLOT);

  logic start_hit, grow_hit, open_hit, split_hit, in_range;
  assign in_range  = (cur_st >= t0) && (cur_st <= t1);
  assign start_hit = cur_used && (!have_start || (cur_st < t0));
  assign grow_hit  = cur_used && in_range && cur_ended && (cur_nt > t1);
  assign open_hit  = cur_used && in_range && !cur_ended;
  assign split_hit = cur_used && (cur_nt >= t0) && (seq_open || (cur_nt <= t1));

  // Decision terms.
  logic held_cont, tap_ok, need_div, div_last_sel;
  assign held_cont = (held_kind == mtgr_pkg::KIND_PAN) || (held_kind == mtgr_pkg::KIND_LONG);
  assign tap_ok    = ((smax - smin) <= {16'd0, tap_max_spread}) &&
                     ((emax - emin) <= {16'd0, tap_max_spread});

  // Divider operand selection.
  logic [SW-1:0] div_num;
  logic [CW-1:0] div_den;
  logic [CW:0]   rem_sh;
  logic          q_bit;
  always_comb begin
    case (div_sel)
      2'd0: div_num = (mode == mtgr_pkg::MODE_TAP) ? sum_lx : sum_ax;
      2'd1: div_num = (mode == mtgr_pkg::MODE_TAP) ? sum_ly : sum_ay;
      2'd2: div_num = sum_bx;
      default: div_num = sum_by;
    endcase
  end
  assign div_den      = (mode == mtgr_pkg::MODE_TAP) ? nl : na;
  assign rem_sh       = {rem[CW-1:0], dq[SW-1]};
  assign q_bit        = (rem_sh >= {1'b0, div_den});
  assign div_last_sel = (mode == mtgr_pkg::MODE_MOTION) ? (div_sel == 2'd3) : (div_sel == 2'd1);

  // Motion thresholds.
  logic [11:0] dx, dy;
  logic        is_pan, is_long;
  assign dx      = (cx > bx) ? (cx - bx) : (bx - cx);
  assign dy      = (cy > by) ? (cy - by) : (by - cy);
  assign is_pan  = (dx >= pan_min_move) || (dy >= pan_min_move);
  assign is_long = ((cmd_r.event_time - first_st) >= {16'd0, long_press_min});

  // Mode chosen at the decision step.
  mtgr_pkg::mode_t mode_pick;
  always_comb begin
    mode_pick = mtgr_pkg::MODE_NONE;
    if (held_cont) begin
      if (held_phase != mtgr_pkg::PH_ENDED) begin
        if ((na == held_count) && (nl == '0)) mode_pick = mtgr_pkg::MODE_HELD_CHG;
        else mode_pick = mtgr_pkg::MODE_HELD_END;
      end
    end else if ((na == '0) && (nl != '0)) begin
      if (tap_ok) mode_pick = mtgr_pkg::MODE_TAP;
    end else if ((na != '0) && (nl == '0)) begin
      mode_pick = mtgr_pkg::MODE_MOTION;
    end
  end
  assign need_div = (mode_pick == mtgr_pkg::MODE_HELD_CHG) ||
                    (mode_pick == mtgr_pkg::MODE_TAP) ||
                    (mode_pick == mtgr_pkg::MODE_MOTION);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mtgr_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.opcode == mtgr_pkg::OP_PROCESS) state_next = mtgr_pkg::ST_START;
          else state_next = mtgr_pkg::ST_SCALE_X;
        end
      end
      mtgr_pkg::ST_SCALE_X: state_next = mtgr_pkg::ST_SCALE_Y;
      mtgr_pkg::ST_SCALE_Y: state_next = mtgr_pkg::ST_FIND;
      mtgr_pkg::ST_FIND:    if (scan_last) state_next = mtgr_pkg::ST_WRITE;
      mtgr_pkg::ST_WRITE:   state_next = mtgr_pkg::ST_IDLE;
      mtgr_pkg::ST_START: begin
        if (scan_last) begin
          if (!have_start && !start_hit) state_next = mtgr_pkg::ST_IDLE;
          else state_next = mtgr_pkg::ST_GROW;
        end
      end
      mtgr_pkg::ST_GROW: begin
        if (slot_phase[start_idx] != mtgr_pkg::PH_ENDED) state_next = mtgr_pkg::ST_SPLIT;
        else if (scan_last && !grow_changed && !grow_hit) state_next = mtgr_pkg::ST_OPEN;
      end
      mtgr_pkg::ST_OPEN:  if (scan_last) state_next = mtgr_pkg::ST_SPLIT;
      mtgr_pkg::ST_SPLIT: if (scan_last) state_next = mtgr_pkg::ST_DECIDE;
      mtgr_pkg::ST_DECIDE: begin
        if (need_div) state_next = mtgr_pkg::ST_DIV_LOAD;
        else if (mode_pick == mtgr_pkg::MODE_HELD_END) state_next = mtgr_pkg::ST_FINISH;
        else state_next = mtgr_pkg::ST_IDLE;
      end
      mtgr_pkg::ST_DIV_LOAD: state_next = mtgr_pkg::ST_DIV_RUN;
      mtgr_pkg::ST_DIV_RUN: begin
        if (div_bit == LAST_BIT) begin
          if (div_last_sel) state_next = mtgr_pkg::ST_FINISH;
          else state_next = mtgr_pkg::ST_DIV_LOAD;
        end
      end
      mtgr_pkg::ST_FINISH: state_next = mtgr_pkg::ST_IDLE;
      default: state_next = mtgr_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy      = (state != mtgr_pkg::ST_IDLE);
    cfg_ready = 1'b1;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) state <= mtgr_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_max_spread <= mtgr_pkg::TAP_MAX_SPREAD_RST;
      pan_min_move   <= mtgr_pkg::PAN_MIN_MOVE_RST;
      long_press_min <= mtgr_pkg::LONG_PRESS_MIN_RST;
      screen_width   <= mtgr_pkg::SCREEN_WIDTH_RST;
      screen_height  <= mtgr_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtgr_pkg::REG_TAP_MAX_SPREAD: tap_max_spread <= cfg_data;
        mtgr_pkg::REG_PAN_MIN_MOVE:   pan_min_move   <= cfg_data[11:0];
        mtgr_pkg::REG_LONG_PRESS_MIN: long_press_min <= cfg_data;
        mtgr_pkg::REG_SCREEN_WIDTH:   screen_width   <= cfg_data[12:0];
        mtgr_pkg::REG_SCREEN_HEIGHT:  screen_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Datapath, slot table and held gesture.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FINGER_SLOTS; i++) begin
        slot_used[i]       <= 1'b0;
        slot_finger[i]     <= '0;
        slot_start_x[i]    <= '0;
        slot_start_y[i]    <= '0;
        slot_start_time[i] <= '0;
        slot_now_x[i]      <= '0;
        slot_now_y[i]      <= '0;
        slot_now_time[i]   <= '0;
        slot_phase[i]      <= mtgr_pkg::PH_BEGAN;
      end
      held_kind    <= mtgr_pkg::KIND_NONE;
      held_phase   <= mtgr_pkg::PH_BEGAN;
      held_count   <= '0;
      held_x       <= '0;
      held_y       <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        mtgr_pkg::ST_IDLE: begin
          if (start) begin
            cmd_r        <= cmd;
            idx          <= '0;
            have_m       <= 1'b0;
            have_f       <= 1'b0;
            have_start   <= 1'b0;
            grow_changed <= 1'b0;
            seq_open     <= 1'b1;
            na           <= '0;
            nl           <= '0;
            sum_ax       <= '0;
            sum_ay       <= '0;
            sum_bx       <= '0;
            sum_by       <= '0;
            sum_lx       <= '0;
            sum_ly       <= '0;
            smin         <= '1;
            emin         <= '1;
            smax         <= '0;
            emax         <= '0;
            t0           <= '0;
            t1           <= '0;
          end
        end
        mtgr_pkg::ST_SCALE_X: pix_x <= mul_pix;
        mtgr_pkg::ST_SCALE_Y: pix_y <= mul_pix;
        mtgr_pkg::ST_FIND: begin
          if (!have_m && (slot_finger[idx] == cmd_r.finger_id)) begin
            have_m <= 1'b1;
            m_idx  <= idx;
          end
          if (!have_f && !cur_used) begin
            have_f <= 1'b1;
            f_idx  <= idx;
          end
          idx <= scan_last ? '0 : idx + 1'b1;
        end
        mtgr_pkg::ST_WRITE: begin
          if (cmd_r.opcode == mtgr_pkg::OP_DOWN) begin
            if (have_m || have_f) begin
              slot_used[have_m ? m_idx : f_idx]       <= 1'b1;
              slot_finger[have_m ? m_idx : f_idx]     <= cmd_r.finger_id;
              slot_start_time[have_m ? m_idx : f_idx] <= cmd_r.event_time;
              slot_start_x[have_m ? m_idx : f_idx]    <= pix_x;
              slot_start_y[have_m ? m_idx : f_idx]    <= pix_y;
              slot_phase[have_m ? m_idx : f_idx]      <= mtgr_pkg::PH_BEGAN;
              slot_now_time[have_m ? m_idx : f_idx]   <= cmd_r.event_time;
              slot_now_x[have_m ? m_idx : f_idx]      <= pix_x;
              slot_now_y[have_m ? m_idx : f_idx]      <= pix_y;
            end
          end else if (have_m) begin
            slot_phase[m_idx]    <= (cmd_r.opcode == mtgr_pkg::OP_MOVE) ?
                                    mtgr_pkg::PH_CHANGED : mtgr_pkg::PH_ENDED;
            slot_now_time[m_idx] <= cmd_r.event_time;
            slot_now_x[m_idx]    <= pix_x;
            slot_now_y[m_idx]    <= pix_y;
          end
        end
        // Earliest sequence start.
        mtgr_pkg::ST_START: begin
          if (start_hit) begin
            have_start <= 1'b1;
            start_idx  <= idx;
            t0         <= cur_st;
          end
          if (scan_last) t1 <= start_hit ? cur_nt : slot_now_time[start_idx];
          idx <= scan_last ? '0 : idx + 1'b1;
        end
        // Widen the end time over lifted fingers until it settles.
        mtgr_pkg::ST_GROW: begin
          if (slot_phase[start_idx] != mtgr_pkg::PH_ENDED) begin
            idx <= '0;
          end else begin
            if (grow_hit) t1 <= cur_nt;
            if (scan_last) begin
              grow_changed <= 1'b0;
              if (!grow_changed && !grow_hit) seq_open <= 1'b0;
            end else if (grow_hit) begin
              grow_changed <= 1'b1;
            end
            idx <= scan_last ? '0 : idx + 1'b1;
          end
        end
        mtgr_pkg::ST_OPEN: begin
          if (open_hit) seq_open <= 1'b1;
          idx <= scan_last ? '0 : idx + 1'b1;
        end
        // Split the sequence into active and lifted fingers.
        mtgr_pkg::ST_SPLIT: begin
          if (split_hit) begin
            if (cur_ended) begin
              nl     <= nl + 1'b1;
              sum_lx <= sum_lx + SW'(slot_now_x[idx]);
              sum_ly <= sum_ly + SW'(slot_now_y[idx]);
              if (cur_st < smin) smin <= cur_st;
              if (cur_st > smax) smax <= cur_st;
              if (cur_nt < emin) emin <= cur_nt;
              if (cur_nt > emax) emax <= cur_nt;
            end else begin
              if (na == '0) first_st <= cur_st;
              na     <= na + 1'b1;
              sum_ax <= sum_ax + SW'(slot_now_x[idx]);
              sum_ay <= sum_ay + SW'(slot_now_y[idx]);
              sum_bx <= sum_bx + SW'(slot_start_x[idx]);
              sum_by <= sum_by + SW'(slot_start_y[idx]);
            end
            if (!seq_open) slot_used[idx] <= 1'b0;
          end
          idx <= scan_last ? '0 : idx + 1'b1;
        end
        mtgr_pkg::ST_DECIDE: begin
          mode    <= mode_pick;
          div_sel <= 2'd0;
          if (held_cont && (held_phase == mtgr_pkg::PH_ENDED) && !seq_open)
            held_kind <= mtgr_pkg::KIND_NONE;
        end
        mtgr_pkg::ST_DIV_LOAD: begin
          dq      <= div_num;
          rem     <= '0;
          div_bit <= '0;
        end
        // One quotient bit a cycle.
        mtgr_pkg::ST_DIV_RUN: begin
          rem     <= q_bit ? (rem_sh - {1'b0, div_den}) : rem_sh;
          dq      <= {dq[SW-2:0], q_bit};
          div_bit <= div_bit + 1'b1;
          if (div_bit == LAST_BIT) begin
            case (div_sel)
              2'd0: cx <= {dq[10:0], q_bit};
              2'd1: cy <= {dq[10:0], q_bit};
              2'd2: bx <= {dq[10:0], q_bit};
              default: by <= {dq[10:0], q_bit};
            endcase
            div_sel <= div_sel + 1'b1;
          end
        end
        mtgr_pkg::ST_FINISH: begin
          case (mode)
            mtgr_pkg::MODE_HELD_CHG: begin
              held_phase   <= mtgr_pkg::PH_CHANGED;
              held_x       <= cx;
              held_y       <= cy;
              result_valid <= 1'b1;
              result       <= {held_kind, mtgr_pkg::PH_CHANGED, 4'(held_count), cx, cy};
            end
            mtgr_pkg::MODE_HELD_END: begin
              held_phase   <= mtgr_pkg::PH_ENDED;
              if (!seq_open) held_kind <= mtgr_pkg::KIND_NONE;
              result_valid <= 1'b1;
              result       <= {held_kind, mtgr_pkg::PH_ENDED, 4'(held_count), held_x, held_y};
            end
            mtgr_pkg::MODE_TAP: begin
              held_phase   <= mtgr_pkg::PH_ENDED;
              held_count   <= nl;
              held_x       <= cx;
              held_y       <= cy;
              held_kind    <= mtgr_pkg::KIND_NONE;
              result_valid <= 1'b1;
              result       <= {mtgr_pkg::KIND_TAP, mtgr_pkg::PH_ENDED, 4'(nl), cx, cy};
            end
            mtgr_pkg::MODE_MOTION: begin
              if (is_pan || is_long) begin
                held_kind    <= is_pan ? mtgr_pkg::KIND_PAN : mtgr_pkg::KIND_LONG;
                held_phase   <= mtgr_pkg::PH_BEGAN;
                held_count   <= na;
                held_x       <= cx;
                held_y       <= cy;
                result_valid <= 1'b1;
                result       <= {(is_pan ? mtgr_pkg::KIND_PAN : mtgr_pkg::KIND_LONG),
                                 mtgr_pkg::PH_BEGAN, 4'(na), cx, cy};
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // A result lasts a single cycle.
  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result shown for more than one cycle");

  // A result never carries the unrecognized kind.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.gesture_kind != mtgr_pkg::KIND_NONE))
    else $error("result with unrecognized kind");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // A result only comes out of work in progress.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without work in progress");

endmodule
